// ===== rtl/core/erlp_pkg.sv =====
// Shared types, field codes and phase sequencing for the event record parser.
// No dependencies; used by every other file of the block.

package erlp_pkg;

	// Length-encoded integer lead bytes
	localparam logic [7:0] LENENC_MAX_DIRECT = 8'hfb;
	localparam logic [7:0] LENENC_2_BYTES    = 8'hfc;
	localparam logic [7:0] LENENC_3_BYTES    = 8'hfd;
	localparam logic [7:0] LENENC_8_BYTES    = 8'hfe;

	// Field codes on the result stream
	localparam logic [3:0] FC_QUERY_LEN  = 4'd13;
	localparam logic [3:0] FC_QUERY_BYTE = 4'd14;
	localparam logic [3:0] FC_END        = 4'd11;
	localparam logic [3:0] FC_UNKNOWN    = 4'd15;

	// Result tdata layout: field_code, field_value, duration_us, zero pad
	localparam int unsigned RES_DATA_W = 136;

	// Parse phase: body phases carry the field code of what they decode
	typedef enum logic [4:0] {
		PH_THREAD      = 5'd0,
		PH_USER_LEN    = 5'd1,
		PH_USER_BYTE   = 5'd2,
		PH_SCHEMA_LEN  = 5'd3,
		PH_SCHEMA_BYTE = 5'd4,
		PH_CLIENT_LEN  = 5'd5,
		PH_CLIENT_BYTE = 5'd6,
		PH_HOST        = 5'd7,
		PH_SERVER_LEN  = 5'd8,
		PH_SERVER_BYTE = 5'd9,
		PH_START       = 5'd10,
		PH_END         = 5'd11,
		PH_DIGEST      = 5'd12,
		PH_QUERY_LEN   = 5'd13,
		PH_QUERY_BYTE  = 5'd14,
		PH_PREFIX      = 5'd16,
		PH_TYPE        = 5'd17
	} phase_t;

	// Integer decoder state and one step's outcome
	typedef struct packed {
		logic [3:0]  left;
		logic [2:0]  shift;
		logic [63:0] acc;
	} lenint_state_t;

	typedef struct packed {
		logic          done;
		logic [63:0]   value;
		lenint_state_t nxt;
	} lenint_result_t;

	// Field that follows a string, given its length or byte phase
	function automatic phase_t string_next(input phase_t p);
		phase_t r;
		case (p)
			PH_USER_LEN,   PH_USER_BYTE:   r = PH_SCHEMA_LEN;
			PH_SCHEMA_LEN, PH_SCHEMA_BYTE: r = PH_CLIENT_LEN;
			PH_CLIENT_LEN, PH_CLIENT_BYTE: r = PH_HOST;
			PH_SERVER_LEN, PH_SERVER_BYTE: r = PH_START;
			default:                       r = PH_PREFIX;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/erlp_lenint.sv =====
// One byte step of the length-encoded integer decoder (combinational).
// Depends on erlp_pkg for the decoder state and result structs.

module erlp_lenint (
	input  logic [7:0]              byte_in,
	input  erlp_pkg::lenint_state_t cur,
	output erlp_pkg::lenint_result_t res
);

	logic [63:0] ins;

	// Byte placed at its little-endian position
	assign ins = {56'd0, byte_in} << {cur.shift, 3'b000};

	always_comb begin
		res = '0;
		if (cur.left == 4'd0) begin
			// Lead byte: value itself, a length marker, or the zero marker
			res.nxt.left  = 4'd0;
			res.nxt.shift = 3'd0;
			res.nxt.acc   = '0;
			if (byte_in <= erlp_pkg::LENENC_MAX_DIRECT) begin
				res.done    = 1'b1;
				res.value   = {56'd0, byte_in};
				res.nxt.acc = {56'd0, byte_in};
			end else if (byte_in == erlp_pkg::LENENC_2_BYTES) begin
				res.nxt.left = 4'd2;
			end else if (byte_in == erlp_pkg::LENENC_3_BYTES) begin
				res.nxt.left = 4'd3;
			end else if (byte_in == erlp_pkg::LENENC_8_BYTES) begin
				res.nxt.left = 4'd8;
			end else begin
				res.done = 1'b1;
			end
		end else begin
			// Continuation byte
			res.value     = cur.acc | ins;
			res.nxt.acc   = cur.acc | ins;
			res.nxt.shift = cur.shift + 3'd1;
			res.nxt.left  = cur.left - 4'd1;
			res.done      = (cur.left == 4'd1);
		end
	end

endmodule

// ===== rtl/core/event_record_lenenc_parser.sv =====
// Top level of the event record parser: input stage, record sequencer, result register.
// Depends on erlp_pkg and erlp_lenint.
//
//  channel   | dir | tdata fields (low bit up)                       | tlast
//  s_axis    | in  | stream_byte[7:0]                                | -
//  m_axis    | out | field_code[3:0] field_value[63:0] duration[63:0]| record_last
//
// One byte per clock is taken while the result side is not stalled; a byte goes into the
// input stage, through the combinational sequencer step, and its result into the result register.
// arst_n clears the control state; the parser then expects a record length prefix.
// A stalled result holds in the result register while the next byte is still taken into
// the input stage; the input side stalls only when both stages are full.

module event_record_lenenc_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // stream_byte[7:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,  // field_code[3:0], field_value[67:4], duration_us[131:68]
	output logic         m_axis_tlast   // record_last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        adv;

	erlp_pkg::phase_t        phase_q, phase_d;
	logic [2:0]              pcount_q, pcount_d;
	erlp_pkg::lenint_state_t int_q, int_d;
	logic [63:0]             sleft_q, sleft_d;
	logic [63:0]             start_q, start_d;
	erlp_pkg::lenint_result_t dec;

	logic        emit;
	logic [3:0]  code;
	logic [63:0] value;
	logic [63:0] dur;
	logic        last;
	logic [63:0] str_dec;
	logic [2:0]  pc;

	logic        valid_s2;
	logic [3:0]  code_s2;
	logic [63:0] value_s2;
	logic [63:0] dur_s2;
	logic        last_s2;

	// Handshake between the stages
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	erlp_lenint u_lenint (
		.byte_in (byte_s1),
		.cur     (int_q),
		.res     (dec)
	);

	assign str_dec = sleft_q - 64'd1;
	assign pc      = (phase_q == erlp_pkg::PH_PREFIX) ? pcount_q : 3'd0;

	// Record sequencer: next state and result for the byte in the input stage
	always_comb begin
		phase_d  = phase_q;
		pcount_d = pcount_q;
		int_d    = int_q;
		sleft_d  = sleft_q;
		start_d  = start_q;
		emit     = 1'b0;
		code     = phase_q[3:0];
		value    = '0;
		dur      = '0;
		last     = 1'b0;
		unique case (phase_q) inside
			erlp_pkg::PH_TYPE: begin
				if (byte_s1 == 8'd0) begin
					phase_d = erlp_pkg::PH_THREAD;
				end else begin
					phase_d  = erlp_pkg::PH_PREFIX;
					pcount_d = 3'd0;
					emit     = 1'b1;
					code     = erlp_pkg::FC_UNKNOWN;
					value    = {56'd0, byte_s1};
					last     = 1'b1;
				end
			end
			erlp_pkg::PH_USER_BYTE, erlp_pkg::PH_SCHEMA_BYTE, erlp_pkg::PH_CLIENT_BYTE,
			erlp_pkg::PH_SERVER_BYTE, erlp_pkg::PH_QUERY_BYTE: begin
				sleft_d = str_dec;
				emit    = 1'b1;
				value   = {56'd0, byte_s1};
				if (str_dec == 64'd0) begin
					phase_d = erlp_pkg::string_next(phase_q);
					if (erlp_pkg::string_next(phase_q) == erlp_pkg::PH_PREFIX) begin
						pcount_d = 3'd0;
						last     = 1'b1;
					end
				end
			end
			erlp_pkg::PH_THREAD, erlp_pkg::PH_USER_LEN, erlp_pkg::PH_SCHEMA_LEN,
			erlp_pkg::PH_CLIENT_LEN, erlp_pkg::PH_HOST, erlp_pkg::PH_SERVER_LEN,
			erlp_pkg::PH_START, erlp_pkg::PH_END, erlp_pkg::PH_DIGEST,
			erlp_pkg::PH_QUERY_LEN: begin
				int_d = dec.nxt;
				if (dec.done) begin
					emit  = 1'b1;
					value = dec.value;
					case (phase_q)
						erlp_pkg::PH_THREAD: phase_d = erlp_pkg::PH_USER_LEN;
						erlp_pkg::PH_HOST: begin
							phase_d = (&dec.value) ? erlp_pkg::PH_START
							                       : erlp_pkg::PH_SERVER_LEN;
						end
						erlp_pkg::PH_START: begin
							start_d = dec.value;
							phase_d = erlp_pkg::PH_END;
						end
						erlp_pkg::PH_END: begin
							phase_d = erlp_pkg::PH_DIGEST;
							dur     = dec.value - start_q;
						end
						erlp_pkg::PH_DIGEST: phase_d = erlp_pkg::PH_QUERY_LEN;
						default: begin
							// String length: bytes follow unless it is empty
							sleft_d = dec.value;
							if (dec.value != 64'd0) begin
								phase_d = erlp_pkg::phase_t'(phase_q + 5'd1);
							end else begin
								phase_d = erlp_pkg::string_next(phase_q);
								if (erlp_pkg::string_next(phase_q) == erlp_pkg::PH_PREFIX) begin
									pcount_d = 3'd0;
									last     = 1'b1;
								end
							end
						end
					endcase
				end
			end
			default: begin
				// Length prefix; a stray phase restarts the prefix count
				int_d.left = 4'd0;
				if (pc == 3'd7) begin
					pcount_d = 3'd0;
					phase_d  = erlp_pkg::PH_TYPE;
				end else begin
					pcount_d = pc + 3'd1;
					phase_d  = erlp_pkg::PH_PREFIX;
				end
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= erlp_pkg::PH_PREFIX;
			pcount_q <= 3'd0;
			int_q    <= '0;
			sleft_q  <= '0;
			start_q  <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			pcount_q <= pcount_d;
			int_q    <= int_d;
			sleft_q  <= sleft_d;
			start_q  <= start_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			code_s2  <= code;
			value_s2 <= value;
			dur_s2   <= dur;
			last_s2  <= last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, dur_s2, value_s2, code_s2};
	assign m_axis_tlast  = last_s2;

endmodule

// ===== rtl/core/erlp_checker.sv =====
// Port-level checks on the result stream of the event record parser, with its bind.
// Depends on erlp_pkg for field codes; attaches to event_record_lenenc_parser.

module erlp_port_sva (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	// A stalled result transfer holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Duration only travels with the end time
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[3:0] != erlp_pkg::FC_END) |-> m_axis_tdata[131:68] == 64'd0)
		else $error("duration outside end-time result");

	// An unknown record type always closes the record
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[3:0] == erlp_pkg::FC_UNKNOWN) |-> m_axis_tlast)
		else $error("unknown type without record end");

	// Only query fields or an unknown type may close a record
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			(m_axis_tdata[3:0] == erlp_pkg::FC_QUERY_LEN) ||
			(m_axis_tdata[3:0] == erlp_pkg::FC_QUERY_BYTE) ||
			(m_axis_tdata[3:0] == erlp_pkg::FC_UNKNOWN))
		else $error("record end on unexpected field");

	// Pad bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[135:132] == 4'd0)
		else $error("nonzero pad bits in result");

endmodule

bind event_record_lenenc_parser erlp_port_sva u_erlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
